>>> rtl/isort_pkg.sv
// shared types and constants for the insertion sort engine
// used by isort_ctrl, isort_datapath and insertion_sort_engine_top
package isort_pkg;

    localparam int DATA_W = 32;

    // commands from controller to datapath
    typedef struct packed {
        logic insert;     // accepted input word: insert value or mark overflow
        logic emit_load;  // move smallest entry into the output register
    } isort_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;   // output register empty or being taken this cycle
        logic last_left;  // exactly one stored entry remains
    } isort_status_t;

endpackage

>>> rtl/insertion_sort_engine_top.sv
// top level of the insertion sort engine
// instantiates isort_ctrl and isort_datapath; depends on isort_pkg
//
// Usage:
//   Input channel s_*: one signed 32-bit value per word in s_tdata, s_tlast
//   marks the final value of a set. While a set is being collected a word is
//   accepted every cycle, placed by a parallel compare-and-shift across the
//   register store. Up to DEPTH values are kept; further values are accepted
//   and dropped, and every result of that set then carries the overflow flag
//   in m_tuser. The word with s_tlast starts the emit: the stored values leave
//   on the m_* channel in ascending order, equal values in arrival order,
//   m_tlast on the largest. The first result is offered once the controller
//   has entered the emit state and loaded the output register, then one per
//   cycle while m_tready is high.
//   s_tready is low during the emit; the next set may start as soon as the
//   final result sits in the output register.
//   A stall on m_tready holds the output word and pauses the drain.
//   Reset (aresetn low, synchronous) empties the store and the output.
module insertion_sort_engine_top
    import isort_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // end_of_run
    output logic [0:0]  m_tuser    // [0] overflowed
);

    isort_cmd_t               cmd;
    isort_status_t            status;
    logic signed [DATA_W-1:0] m_value;
    logic                     m_ovf;

    isort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    isort_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_value  ($signed(s_tdata)),
        .cmd      (cmd),
        .status   (status),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_value  (m_value),
        .m_last   (m_tlast),
        .m_ovf    (m_ovf)
    );

    assign m_tdata    = m_value;
    assign m_tuser[0] = m_ovf;

endmodule

>>> rtl/isort_ctrl.sv
// controller state machine for the insertion sort engine
// depends on isort_pkg for the command and status structs
module isort_ctrl
    import isort_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  isort_status_t status,
    output isort_cmd_t    cmd
);

    localparam logic ST_FILL = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    // handshake and commands
    assign s_tready      = (state_reg == ST_FILL);
    assign cmd.insert    = (state_reg == ST_FILL) && s_tvalid;
    assign cmd.emit_load = (state_reg == ST_EMIT) && status.out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.last_left) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

    // no input word is taken while the set is being emitted
    a_no_accept_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !cmd.insert)
        else $error("insert command while emitting");

    // a last word always starts an emit
    a_last_starts_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && s_tlast) |=> (state_reg == ST_EMIT))
        else $error("last word did not start emit");

endmodule

>>> rtl/isort_datapath.sv
// sorted register store with parallel compare-and-shift insert,
// shift-down emit and output register; depends on isort_pkg
module isort_datapath
    import isort_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [DATA_W-1:0] s_value,
    input  isort_cmd_t               cmd,
    output isort_status_t            status,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic signed [DATA_W-1:0] m_value,
    output logic                     m_last,
    output logic                     m_ovf
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] store_reg  [DEPTH];
    logic signed [DATA_W-1:0] store_next [DEPTH];
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg, out_ovf_reg;
    logic [DEPTH-1:0]         gt;
    logic                     full;

    assign full             = (count_reg == CNT_W'(DEPTH));
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.last_left = (count_reg == CNT_W'(1));

    // entries above the new value, among the valid ones
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CNT_W'(i) < count_reg) && (store_reg[i] > s_value);
        end
    end

    // store update: insert shifts larger entries up, emit shifts all down
    always_comb begin
        store_next = store_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.insert) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
                for (int i = 0; i < DEPTH; i++) begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                        store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                    end else if (gt[i] || CNT_W'(i) == count_reg) begin
                        store_next[i] = s_value;
                    end
                end
            end
        end else if (cmd.emit_load) begin
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
                store_next[i] = store_reg[i + 1];
            end
            if (status.last_left) begin
                ovf_next = 1'b0;
            end
        end
    end

    // output register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        store_reg <= store_next;
        if (cmd.emit_load) begin
            out_value_reg <= store_reg[0];
            out_last_reg  <= status.last_left;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_last   = out_last_reg;
    assign m_ovf    = out_ovf_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load && status.last_left) |=> (count_reg == '0) && !ovf_reg)
        else $error("set not cleared after final word");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.insert && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the store");

    a_no_load_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !cmd.emit_load)
        else $error("output register overwritten while stalled");

    // valid entries stay in ascending order
    for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order
        a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
            (CNT_W'(g + 1) < count_reg) |-> (store_reg[g] <= store_reg[g + 1]))
            else $error("store out of order");
    end

endmodule

>>> tb/insertion_sort_engine_top_tb.sv
// testbench for insertion_sort_engine_top: sends sets of signed words, predicts the sorted emit
// and checks every result word; depends on the rtl top level and isort_pkg
`timescale 1ns / 100ps

module insertion_sort_engine_top_tb
    import isort_pkg::*;
;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 9;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 20;

    // one expected result word
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     run_end;
        logic                     ovf;
    } sorted_word_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;   // [31:0] value
    logic              s_tlast;   // is_last
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;   // [31:0] sorted_value
    logic              m_tlast;   // end_of_run
    logic [0:0]        m_tuser;   // [0] overflowed

    // predictor state: current set in ascending order plus the dropped flag
    logic signed [DATA_W-1:0] held_values[$];
    bit                       set_overflow;
    sorted_word_t             pending_sorted[$];

    bit send_gaps;
    bit sink_gaps;
    int error_count;
    int words_sent;
    int idle_cycles;

    insertion_sort_engine_top #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // stable insert of one accepted word; on the last word the set is queued as results
    task automatic sort_accepted_word(input logic signed [DATA_W-1:0] v, input logic last);
        int           pos;
        sorted_word_t w;
        pos = 0;
        if (held_values.size() < DEPTH) begin
            while (pos < held_values.size() && held_values[pos] <= v)
                pos++;
            held_values.insert(pos, v);
        end else begin
            set_overflow = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < held_values.size(); k++) begin
                w.value   = held_values[k];
                w.run_end = (k == held_values.size() - 1);
                w.ovf     = set_overflow;
                pending_sorted.push_back(w);
            end
            held_values.delete();
            set_overflow = 1'b0;
        end
    endtask

    // send one word, with a random gap before it when gaps are on
    task automatic send_word(input logic signed [DATA_W-1:0] v, input logic last);
        int gap;
        gap = send_gaps ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        words_sent++;
        sort_accepted_word(v, last);
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value(input int mode);
        logic signed [DATA_W-1:0] v;
        case (mode)
            0: v = $urandom_range(0, 9) - 5;
            1: v = ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // random set; lengths beyond DEPTH now and then to force drops
    task automatic send_random_set();
        int len;
        int sel;
        int mode;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            len = $urandom_range(DEPTH + 1, DEPTH + 4);
        else if (sel == 1)
            len = DEPTH;
        else
            len = $urandom_range(1, DEPTH - 1);
        for (int i = 0; i < len; i++) begin
            mode = $urandom_range(0, 4);
            send_word(draw_value(mode), i == len - 1);
        end
    endtask

    // hold off the sender until the whole emit is taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_sorted.size() > 0) @(posedge aclk);
    endtask

    // extremes, duplicates, single word set, descending set with drops
    task automatic test_directed();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        send_word(32'sh7fffffff, 1'b0);
        send_word(32'sh80000000, 1'b0);
        send_word(32'sh00000000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(32'sh80000000, 1'b1);
        send_word(-32'sd7, 1'b1);
        // full store, then the last word is dropped
        for (int i = 0; i <= DEPTH; i++)
            send_word(1000 - 100 * i, i == DEPTH);
        wait_drained();
    endtask

    task automatic test_random_gaps();
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        while (words_sent < 230)
            send_random_set();
    endtask

    task automatic test_drain_pause();
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
        repeat (3) begin
            send_random_set();
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        while (words_sent < 320)
            send_random_set();
    endtask

    // result sink with a random stall per word
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = sink_gaps ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            forever begin
                @(posedge aclk);
                if (m_tvalid) break;
            end
        end
    end

    // compare each taken result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        sorted_word_t exp_word;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("unexpected word %0d", $signed(m_tdata)));
            end else begin
                exp_word = pending_sorted.pop_front();
                if ($signed(m_tdata) !== exp_word.value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              $signed(m_tdata), exp_word.value));
                if (m_tlast !== exp_word.run_end)
                    report_mismatch($sformatf("end_of_run %b, expected %b",
                                              m_tlast, exp_word.run_end));
                if (m_tuser[0] !== exp_word.ovf)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              m_tuser[0], exp_word.ovf));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset, test sequence, final verdict
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        send_gaps    = 1'b0;
        sink_gaps    = 1'b0;
        set_overflow = 1'b0;
        error_count  = 0;
        words_sent   = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_gaps();
        test_drain_pause();
        test_back_to_back();

        s_tvalid <= 1'b0;
        while (pending_sorted.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_sorted.size() != 0)
            report_mismatch("expected words left over");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
